// ----- rtl/game_pad_poll_decoder_unit_assert.svh -----
// Assertion macros shared by the game pad poll decoder RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef GAME_PAD_POLL_DECODER_UNIT_ASSERT_SVH
`define GAME_PAD_POLL_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside of reset.
`define GPPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define GPPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GPPD_ASSERT(lbl, prop, msg)
`define GPPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/gppd_pkg.sv -----
// Package of the game pad poll decoder: payload types, controller kinds,
// configuration indexes and protocol constants. No dependencies.
package gppd_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ID_DIGITAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_RED      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_GREEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_PRESSURE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_NEGCON   = 3'd4;

  // Reset values of the id registers.
  localparam logic [7:0] ID_DIGITAL_RST  = 8'h41;
  localparam logic [7:0] ID_RED_RST      = 8'h73;
  localparam logic [7:0] ID_GREEN_RST    = 8'h53;
  localparam logic [7:0] ID_PRESSURE_RST = 8'h79;
  localparam logic [7:0] ID_NEGCON_RST   = 8'h23;

  // Command bytes sent to the controller.
  localparam logic [7:0] TX_START = 8'h01;
  localparam logic [7:0] TX_POLL  = 8'h42;
  localparam logic [7:0] TX_IDLE  = 8'hFF;

  // Axis bias and layout constants.
  localparam logic [7:0] AXIS_BIAS = 8'h80;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Received byte numbers within one poll.
  localparam logic [3:0] BYTE_ID     = 4'd1;
  localparam logic [3:0] BYTE_BTN_LO = 4'd3;
  localparam logic [3:0] BYTE_BTN_HI = 4'd4;
  localparam logic [3:0] BYTE_AX_0   = 4'd5;
  localparam logic [3:0] BYTE_AX_1   = 4'd6;
  localparam logic [3:0] BYTE_AX_2   = 4'd7;
  localparam logic [3:0] BYTE_LAST   = 4'd8;

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EXCH  = 1'b1;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_DIGITAL  = 3'd1,
    KIND_RED      = 3'd2,
    KIND_GREEN    = 3'd3,
    KIND_PRESSURE = 3'd4,
    KIND_NEGCON   = 3'd5
  } kind_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_EXCH  = 1'b1
  } op_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        tx_byte;
    logic              tx_valid;
    logic              attention;
    logic              report_valid;
    logic [7:0]        buttons_main;
    logic [3:0]        buttons_misc;
    logic [3:0]        hat;
    logic signed [7:0] axis_x;
    logic signed [7:0] axis_y;
    logic signed [7:0] axis_rx;
    logic signed [7:0] axis_ry;
  } out_item_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    kind_t      kind;
  } q_entry_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ----- rtl/game_pad_poll_decoder_unit.sv -----
// Game pad poll decoder, host side of a controller poll.
//
// Input channel (in_valid, in_stall, in_data): each transfer is either a start
// (command 0) or one finished byte exchange (command 1) with the received byte.
// Result channel (out_valid, out_stall, out_data): one result per input
// transfer, in order: the next byte to send, the select line state and the
// report built so far, final where report_valid is set.
// Configuration port (cfg_we, cfg_idx, cfg_wdata): writes the five controller
// id registers; write only while no item is in flight.
// Each input item is registered in the queue and then in the output register
// before its result is valid.
// Throughput: one item per cycle while the output is not stalled; the back end
// takes one queued item each cycle when the output register is free or draining.
// A stalled result holds in the output register while the queue of QUEUE_DEPTH
// entries keeps taking input; in_stall rises only when that queue is full.
// Reset clears the queue, the poll state and the report and restores the
// default ids; no result is pending after reset.
// Uses gppd_pkg, gppd_front, gppd_queue and gppd_back.
module game_pad_poll_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gppd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gppd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gppd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gppd_pkg::out_item_t             out_data
);
  import gppd_pkg::*;

  logic      push, pop;
  q_entry_t  push_entry, head;
  q_status_t q_status;

  assign in_stall = q_status.full;

  // Accept and classify input transfers.
  gppd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple the front from the back.
  gppd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Sequence the poll and decode the report.
  gppd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/gppd_front.sv -----
// Front of the game pad poll decoder: holds the id registers, accepts input
// items and classifies each one (operation and matched controller kind). Uses gppd_pkg.
module gppd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gppd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [gppd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  input  gppd_pkg::in_item_t                  in_data,
  input  gppd_pkg::q_status_t                 q_status,
  output logic                                push,
  output gppd_pkg::q_entry_t                  push_entry
);
  import gppd_pkg::*;

  logic [7:0] id_digital_r, id_red_r, id_green_r, id_pressure_r, id_negcon_r;
  kind_t      match_kind;

  // Configuration writes to the id registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_digital_r  <= ID_DIGITAL_RST;
      id_red_r      <= ID_RED_RST;
      id_green_r    <= ID_GREEN_RST;
      id_pressure_r <= ID_PRESSURE_RST;
      id_negcon_r   <= ID_NEGCON_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ID_DIGITAL:  id_digital_r  <= cfg_wdata;
        CFG_ID_RED:      id_red_r      <= cfg_wdata;
        CFG_ID_GREEN:    id_green_r    <= cfg_wdata;
        CFG_ID_PRESSURE: id_pressure_r <= cfg_wdata;
        CFG_ID_NEGCON:   id_negcon_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Match the received byte against the ids; the first match wins.
  always_comb begin
    if (in_data.rx_byte == id_digital_r) begin
      match_kind = KIND_DIGITAL;
    end else if (in_data.rx_byte == id_red_r) begin
      match_kind = KIND_RED;
    end else if (in_data.rx_byte == id_green_r) begin
      match_kind = KIND_GREEN;
    end else if (in_data.rx_byte == id_pressure_r) begin
      match_kind = KIND_PRESSURE;
    end else if (in_data.rx_byte == id_negcon_r) begin
      match_kind = KIND_NEGCON;
    end else begin
      match_kind = KIND_NONE;
    end
  end

  // A transfer enters the queue whenever the queue has room.
  assign push               = in_valid && !q_status.full;
  assign push_entry.op      = (in_data.command == CMD_START) ? OP_START : OP_EXCH;
  assign push_entry.rx_byte = in_data.rx_byte;
  assign push_entry.kind    = match_kind;

endmodule

// ----- rtl/gppd_queue.sv -----
// Short FIFO between the front and back of the game pad poll decoder.
// Uses gppd_pkg and the assertion macro header.
module gppd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gppd_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output gppd_pkg::q_entry_t  head,
  output gppd_pkg::q_status_t status
);
  import gppd_pkg::*;
  `include "game_pad_poll_decoder_unit_assert.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head             = mem_r[rd_ptr_r];
  assign status.full      = (count_r == FULL_CNT);
  assign status.not_empty = (count_r != '0);

  `GPPD_ASSERT(a_q_no_overflow, count_r <= FULL_CNT, "queue fill count beyond depth")
  `GPPD_ASSERT(a_q_pop_nonempty, pop |-> status.not_empty, "queue popped while empty")
  `GPPD_ASSERT(a_q_push_room, push |-> !status.full, "queue pushed while full")
  `GPPD_ASSERT(a_q_ptrs_empty, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r),
               "queue pointers differ while empty")

endmodule

// ----- rtl/gppd_back.sv -----
// Back of the game pad poll decoder: poll sequencing, report decoding and
// the output register. Uses gppd_pkg and the assertion macro header.
module gppd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gppd_pkg::q_entry_t  head,
  input  gppd_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output gppd_pkg::out_item_t out_data
);
  import gppd_pkg::*;
  `include "game_pad_poll_decoder_unit_assert.svh"

  logic       active_r, active_nxt;
  logic [3:0] idx_r, idx_nxt;
  kind_t      kind_r, kind_nxt;
  logic [7:0] main_r, main_nxt;
  logic [3:0] misc_r, misc_nxt;
  logic [3:0] hat_r, hat_nxt;
  logic [7:0] ax_x_r, ax_x_nxt, ax_y_r, ax_y_nxt;
  logic [7:0] ax_rx_r, ax_rx_nxt, ax_ry_r, ax_ry_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_item_nxt;

  logic       neg, finish;
  logic [7:0] d, tx;
  logic       txv, rv;

  // Take the next queued item whenever the output register is free or draining.
  assign pop = q_status.not_empty && (!out_valid_r || !out_stall);
  assign d   = head.rx_byte;
  assign neg = (kind_r == KIND_NEGCON);

  // Poll sequencing and report decoding of one item.
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    kind_nxt   = kind_r;
    main_nxt   = main_r;
    misc_nxt   = misc_r;
    hat_nxt    = hat_r;
    ax_x_nxt   = ax_x_r;
    ax_y_nxt   = ax_y_r;
    ax_rx_nxt  = ax_rx_r;
    ax_ry_nxt  = ax_ry_r;
    tx         = '0;
    txv        = 1'b0;
    rv         = 1'b0;
    finish     = 1'b0;
    if (head.op == OP_START) begin
      main_nxt   = '0;
      misc_nxt   = '0;
      hat_nxt    = '0;
      ax_x_nxt   = '0;
      ax_y_nxt   = '0;
      ax_rx_nxt  = '0;
      ax_ry_nxt  = '0;
      active_nxt = 1'b1;
      idx_nxt    = '0;
      kind_nxt   = KIND_NONE;
      tx         = TX_START;
      txv        = 1'b1;
    end else if (active_r) begin
      case (idx_r)
        BYTE_ID: begin
          kind_nxt = head.kind;
          finish   = (head.kind == KIND_NONE);
        end
        BYTE_BTN_LO: begin
          if (!d[3]) misc_nxt[1] = 1'b1;
          hat_nxt = ~d[7:4] & NIBBLE_MASK;
          if (!neg) begin
            if (!d[0]) misc_nxt[0] = 1'b1;
            if (kind_r != KIND_DIGITAL) begin
              if (!d[1]) misc_nxt[2] = 1'b1;
              if (!d[2]) misc_nxt[3] = 1'b1;
            end
          end
        end
        BYTE_BTN_HI: begin
          if (!d[3]) main_nxt[7] = 1'b1;
          if (!d[4]) main_nxt[3] = 1'b1;
          if (!d[5]) main_nxt[1] = 1'b1;
          if (!neg) begin
            if (!d[0]) main_nxt[4] = 1'b1;
            if (!d[1]) main_nxt[5] = 1'b1;
            if (!d[2]) main_nxt[6] = 1'b1;
            if (!d[6]) main_nxt[0] = 1'b1;
            if (!d[7]) main_nxt[2] = 1'b1;
            finish = (kind_r == KIND_DIGITAL);
          end
        end
        BYTE_AX_0: begin
          if (neg) ax_x_nxt = d ^ AXIS_BIAS;
          else     ax_rx_nxt = d ^ AXIS_BIAS;
        end
        BYTE_AX_1: begin
          // Negcon: (128 - b) * 2 wraps to minus twice the byte.
          if (neg) begin
            if (d > AXIS_BIAS) ax_ry_nxt = 8'd0 - {d[6:0], 1'b0};
          end else begin
            ax_ry_nxt = d ^ AXIS_BIAS;
          end
        end
        BYTE_AX_2: begin
          // Negcon: (b + 128) * 2 wraps to twice the byte.
          if (neg) begin
            if (d < AXIS_BIAS) ax_ry_nxt = {d[6:0], 1'b0};
          end else begin
            ax_x_nxt = d ^ AXIS_BIAS;
          end
        end
        BYTE_LAST: begin
          if (neg) begin
            if (d > AXIS_BIAS) main_nxt[6] = 1'b1;
          end else begin
            ax_y_nxt = d ^ AXIS_BIAS;
          end
          finish = 1'b1;
        end
        default: begin
          // The first and third bytes carry nothing; a byte past the last ends the poll.
          finish = (idx_r > BYTE_LAST);
        end
      endcase
      if (finish) begin
        active_nxt = 1'b0;
        idx_nxt    = '0;
        rv         = 1'b1;
      end else begin
        tx      = (idx_r == '0) ? TX_POLL : TX_IDLE;
        txv     = 1'b1;
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  // Result of the item, built from the updated report.
  always_comb begin
    out_item_nxt.tx_byte      = tx;
    out_item_nxt.tx_valid     = txv;
    out_item_nxt.attention    = txv;
    out_item_nxt.report_valid = rv;
    out_item_nxt.buttons_main = main_nxt;
    out_item_nxt.buttons_misc = misc_nxt;
    out_item_nxt.hat          = hat_nxt;
    out_item_nxt.axis_x       = ax_x_nxt;
    out_item_nxt.axis_y       = ax_y_nxt;
    out_item_nxt.axis_rx      = ax_rx_nxt;
    out_item_nxt.axis_ry      = ax_ry_nxt;
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      kind_r      <= KIND_NONE;
      main_r      <= '0;
      misc_r      <= '0;
      hat_r       <= '0;
      ax_x_r      <= '0;
      ax_y_r      <= '0;
      ax_rx_r     <= '0;
      ax_ry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        active_r <= active_nxt;
        idx_r    <= idx_nxt;
        kind_r   <= kind_nxt;
        main_r   <= main_nxt;
        misc_r   <= misc_nxt;
        hat_r    <= hat_nxt;
        ax_x_r   <= ax_x_nxt;
        ax_y_r   <= ax_y_nxt;
        ax_rx_r  <= ax_rx_nxt;
        ax_ry_r  <= ax_ry_nxt;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GPPD_ASSERT(a_idle_index, !active_r |-> (idx_r == '0), "byte index set with no poll")
  `GPPD_ASSERT(a_index_range, idx_r <= BYTE_LAST, "byte index past the last byte")
  `GPPD_ASSERT(a_report_ends, (out_valid_r && out_data_r.report_valid) |->
               (!out_data_r.tx_valid && !out_data_r.attention),
               "report given while another exchange is requested")
  `GPPD_ASSERT(a_kind_after_id, (active_r && idx_r > BYTE_ID) |-> (kind_r != KIND_NONE),
               "poll continues past the id with no controller kind")

endmodule
